// ===== src/polynomial_easing_evaluator_unit_defines.svh =====
// Assertion macros shared by the easing evaluator RTL.
`ifndef POLYNOMIAL_EASING_EVALUATOR_UNIT_DEFINES_SVH
`define POLYNOMIAL_EASING_EVALUATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define PEU_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("easing evaluator check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define PEU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("easing evaluator check failed");

`endif

// ===== src/peu_pkg.sv =====
// Shared types and codes of the polynomial easing evaluator.
`default_nettype none

package peu_pkg;

  localparam int unsigned VALUE_BITS     = 32;
  localparam int unsigned CFG_INDEX_BITS = 3;

  typedef enum logic [2:0] {
    CURVE_QUAD   = 3'd0,
    CURVE_CUBIC  = 3'd1,
    CURVE_QUART  = 3'd2,
    CURVE_QUINT  = 3'd3,
    CURVE_BACK   = 3'd4,
    CURVE_BOUNCE = 3'd5
  } curve_kind_e;

  typedef enum logic [1:0] {
    DIR_IN    = 2'd0,
    DIR_OUT   = 2'd1,
    DIR_INOUT = 2'd2
  } direction_e;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_CURVE_KIND    = 3'd0,
    REG_DIRECTION     = 3'd1,
    REG_START_VALUE   = 3'd2,
    REG_CHANGE_AMOUNT = 3'd3,
    REG_DURATION      = 3'd4
  } reg_index_e;

  typedef struct packed {
    logic [2:0]                   curve_kind;
    logic [1:0]                   direction;
    logic signed [VALUE_BITS-1:0] start_value;
    logic signed [VALUE_BITS-1:0] change_amount;
  } curve_cfg_t;

endpackage

`default_nettype wire

// ===== src/polynomial_easing_evaluator_unit.sv =====
// Top level of the polynomial easing evaluator.
// Evaluates start + change * f(t / duration) in Q16.16 for quad, cubic, quart, quint, back
// and bounce curves, eased in, out or in-out, saturating to 32 bits. The pipeline holds
// FRACTION_BITS + 10 stages (26 at the default) and takes one sample every cycle while
// in_ready_o is high, which it is unless every stage holds an item and the output is not
// taken; the depth is set by the divider that forms the progress fraction one quotient bit
// per stage. Any stage that holds no item keeps filling while the output waits. The user
// must write configuration only while no item is in flight; the block does not enforce this.
`default_nettype none
`include "polynomial_easing_evaluator_unit_defines.svh"

module polynomial_easing_evaluator_unit #(
  parameter int unsigned TIME_BITS     = 16,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [peu_pkg::CFG_INDEX_BITS-1:0]   cfg_index_i,
  input  wire logic [peu_pkg::VALUE_BITS-1:0]       cfg_data_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic [TIME_BITS-1:0]                 elapsed_time_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic signed [peu_pkg::VALUE_BITS-1:0]     eased_value_o,
  output logic                                      saturated_o
);

  import peu_pkg::*;

  localparam int unsigned DIV_STAGES = FRACTION_BITS + 2;
  localparam int unsigned NST        = DIV_STAGES + 8;

  // configuration registers
  logic [2:0]                   kind_q;
  logic [1:0]                   dir_q;
  logic signed [VALUE_BITS-1:0] start_q, change_q;
  logic [TIME_BITS-1:0]         duration_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q     <= CURVE_QUAD;
      dir_q      <= DIR_IN;
      start_q    <= '0;
      change_q   <= 32'sd65536;
      duration_q <= TIME_BITS'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_CURVE_KIND:    kind_q     <= cfg_data_i[2:0];
        REG_DIRECTION:     dir_q      <= cfg_data_i[1:0];
        REG_START_VALUE:   start_q    <= $signed(cfg_data_i);
        REG_CHANGE_AMOUNT: change_q   <= $signed(cfg_data_i);
        REG_DURATION:      duration_q <= cfg_data_i[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  curve_cfg_t cfg;
  assign cfg = '{curve_kind: kind_q, direction: dir_q,
                 start_value: start_q, change_amount: change_q};

  // Stage k loads when some stage at or after k is empty or the result is taken.
  logic [NST-1:0] vld_q;
  logic [NST-1:0] en;

  for (genvar k = 0; k < NST; k++) begin : g_ctl
    assign en[k] = !(&vld_q[NST-1:k]) || out_ready_i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en[k]) begin
        vld_q[k] <= (k == 0) ? in_valid_i : vld_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NST-1];

  logic [FRACTION_BITS:0] progress;
  logic                   first_half;

  peu_divider #(
    .TIME_BITS     (TIME_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_divider (
    .clk_i      (clk_i),
    .en_i       (en[DIV_STAGES-1:0]),
    .duration_i (duration_q),
    .time_i     (elapsed_time_i),
    .p_o        (progress),
    .half_o     (first_half)
  );

  peu_curve #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_curve (
    .clk_i         (clk_i),
    .en_i          (en[NST-1:DIV_STAGES]),
    .cfg_i         (cfg),
    .p_i           (progress),
    .half_i        (first_half),
    .eased_value_o (eased_value_o),
    .saturated_o   (saturated_o)
  );

  `PEU_ASSERT_SAME(a_sat_clips, out_valid_o && saturated_o, eased_value_o == 32'sh7fffffff || eased_value_o == 32'sh80000000)
  `PEU_ASSERT_SAME(a_empty_out_ready, !out_valid_o, in_ready_o)
  `PEU_ASSERT_NEXT(a_accept_fills, in_valid_i && in_ready_o, vld_q[0])

endmodule

`default_nettype wire

// ===== src/peu_divider.sv =====
// Clamp and pipelined restoring divider producing progress = t * 2^F / duration.
`default_nettype none

module peu_divider #(
  parameter int unsigned TIME_BITS     = 16,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic                       clk_i,
  input  wire logic [FRACTION_BITS+1:0]   en_i,
  input  wire logic [TIME_BITS-1:0]       duration_i,
  input  wire logic [TIME_BITS-1:0]       time_i,
  output logic      [FRACTION_BITS:0]     p_o,
  output logic                            half_o
);

  localparam int unsigned NSTEP = FRACTION_BITS + 1;

  logic [TIME_BITS-1:0]   rem_q  [NSTEP+1];
  logic [FRACTION_BITS:0] quo_q  [NSTEP+1];
  logic                   half_q [NSTEP+1];

  logic [TIME_BITS-1:0] t_clamp;
  logic [TIME_BITS:0]   t_twice;
  logic                 first_half;

  always_comb begin
    t_clamp    = (time_i > duration_i) ? duration_i : time_i;
    t_twice    = {t_clamp, 1'b0};
    first_half = (duration_i != '0) && (t_twice < {1'b0, duration_i});
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0]  <= t_clamp;
      quo_q[0]  <= '0;
      half_q[0] <= first_half;
    end
  end

  // One quotient bit per stage; the first step tests t >= d without doubling.
  for (genvar j = 1; j <= NSTEP; j++) begin : g_step
    logic [TIME_BITS:0] cand;
    logic [TIME_BITS:0] diff;
    logic               ge;

    always_comb begin
      cand = (j == 1) ? {1'b0, rem_q[j-1]} : {rem_q[j-1], 1'b0};
      ge   = cand >= {1'b0, duration_i};
      diff = cand - {1'b0, duration_i};
    end

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        rem_q[j]  <= ge ? diff[TIME_BITS-1:0] : cand[TIME_BITS-1:0];
        quo_q[j]  <= {quo_q[j-1][FRACTION_BITS-1:0], ge};
        half_q[j] <= half_q[j-1];
      end
    end
  end

  // zero duration counts as a finished animation
  assign p_o    = (duration_i == '0) ? {1'b1, {FRACTION_BITS{1'b0}}} : quo_q[NSTEP];
  assign half_o = half_q[NSTEP];

endmodule

`default_nettype wire

// ===== src/peu_curve.sv =====
// Curve evaluation, direction shaping, scaling and saturation pipeline.
`default_nettype none

module peu_curve #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic [7:0]                  en_i,
  input  wire peu_pkg::curve_cfg_t         cfg_i,
  input  wire logic [FRACTION_BITS:0]      p_i,
  input  wire logic                        half_i,
  output logic signed [peu_pkg::VALUE_BITS-1:0] eased_value_o,
  output logic                             saturated_o
);

  import peu_pkg::*;

  localparam int unsigned F  = FRACTION_BITS;
  localparam int unsigned CW = F + 4;
  localparam int unsigned PW = VALUE_BITS + CW;

  localparam longint ONEL = longint'(1) << F;
  localparam logic signed [CW-1:0] ONE  = CW'(ONEL);
  localparam logic signed [CW-1:0] HALF = CW'(ONEL >> 1);

  localparam longint unsigned BACK_S_Q32  = ((64'd170158 << 32) + 64'd50000) / 64'd100000;
  localparam longint unsigned BACK_S2_Q32 = (BACK_S_Q32 * 64'd1525 + 64'd500) / 64'd1000;
  localparam logic signed [CW-1:0] S1 =
    CW'((BACK_S_Q32 + (64'd1 << (31 - F))) >> (32 - F));
  localparam logic signed [CW-1:0] S2 =
    CW'((BACK_S2_Q32 + (64'd1 << (31 - F))) >> (32 - F));

  localparam logic signed [CW-1:0] OFF1  = CW'((12 * ONEL + 11) / 22);
  localparam logic signed [CW-1:0] OFF2  = CW'((18 * ONEL + 11) / 22);
  localparam logic signed [CW-1:0] OFF3  = CW'((42 * ONEL + 22) / 44);
  localparam logic signed [CW-1:0] LIFT1 = CW'((3 * ONEL) / 4);
  localparam logic signed [CW-1:0] LIFT2 = CW'((15 * ONEL) / 16);
  localparam logic signed [CW-1:0] LIFT3 = CW'((63 * ONEL) / 64);

  localparam logic [F+1:0] ONE_X = (F+2)'(1) << F;
  localparam logic [F+1:0] TWO_X = (F+2)'(2) << F;
  localparam logic [F:0]   ONE_Y = {1'b1, {F{1'b0}}};
  localparam logic [F+4:0] Y4    = (F+5)'(4) << F;
  localparam logic [F+4:0] Y8    = (F+5)'(8) << F;
  localparam logic [F+4:0] Y10   = (F+5)'(10) << F;

  function automatic logic signed [CW-1:0] fx_mul(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
    logic signed [2*CW-1:0] prod;
    prod = (2*CW)'(a) * (2*CW)'(b) + (2*CW)'(HALF);
    return CW'(prod >>> F);
  endfunction

  logic is_bounce, is_back, is_inout, is_out;
  logic signed [CW-1:0] s_sel;

  always_comb begin
    is_bounce = cfg_i.curve_kind >= CURVE_BOUNCE;
    is_back   = cfg_i.curve_kind == CURVE_BACK;
    is_inout  = cfg_i.direction[1];
    is_out    = cfg_i.direction == DIR_OUT;
    s_sel     = is_inout ? S2 : S1;
  end

  // Stage 0: curve argument and bounce segment
  logic [F+1:0]         xw;
  logic [F:0]           y;
  logic [F+4:0]         y11;
  logic signed [CW-1:0] off, lift;

  always_comb begin
    priority if (is_inout) begin
      xw = half_i ? {p_i, 1'b0} : TWO_X - {p_i, 1'b0};
    end else if (is_out) begin
      xw = ONE_X - {1'b0, p_i};
    end else begin
      xw = {1'b0, p_i};
    end
    y   = ONE_Y - xw[F:0];
    y11 = {4'b0000, y} * (F+5)'(11);
    priority if (y11 < Y4) begin
      off  = '0;
      lift = '0;
    end else if (y11 < Y8) begin
      off  = OFF1;
      lift = LIFT1;
    end else if (y11 < Y10) begin
      off  = OFF2;
      lift = LIFT2;
    end else begin
      off  = OFF3;
      lift = LIFT3;
    end
  end

  logic [F:0]           c0_x_q;
  logic signed [CW-1:0] c0_dx_q, c0_lift_q;
  logic                 c0_half_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      c0_x_q    <= xw[F:0];
      c0_dx_q   <= $signed({3'b000, y}) - off;
      c0_lift_q <= lift;
      c0_half_q <= half_i;
    end
  end

  // Stage 1: square (or bounce square) and (s+1)x
  logic signed [CW-1:0] c0_xs;
  logic signed [CW-1:0] m1_r_q, m1_b_q, m1_lift_q, m1_xs_q;
  logic                 m1_half_q;

  assign c0_xs = $signed({3'b000, c0_x_q});

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      m1_r_q    <= is_bounce ? fx_mul(c0_dx_q, c0_dx_q) : fx_mul(c0_xs, c0_xs);
      m1_b_q    <= fx_mul(s_sel + ONE, c0_xs);
      m1_lift_q <= c0_lift_q;
      m1_xs_q   <= c0_xs;
      m1_half_q <= c0_half_q;
    end
  end

  // Stage 2: back product, bounce finish, third power, or quad pass-through
  logic signed [CW+6:0] sq_w, bsc_w;
  logic signed [CW-1:0] m2_r_d;
  logic signed [CW-1:0] m2_r_q, m2_xs_q;
  logic                 m2_half_q;

  always_comb begin
    sq_w  = (CW+7)'(m1_r_q);
    bsc_w = ((sq_w <<< 7) - (sq_w <<< 3) + sq_w + (CW+7)'(8)) >>> 4;
    priority if (is_bounce) begin
      m2_r_d = ONE - (CW'(bsc_w) + m1_lift_q);
    end else if (is_back) begin
      m2_r_d = fx_mul(m1_r_q, m1_b_q - s_sel);
    end else if (cfg_i.curve_kind == CURVE_QUAD) begin
      m2_r_d = m1_r_q;
    end else begin
      m2_r_d = fx_mul(m1_r_q, m1_xs_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      m2_r_q    <= m2_r_d;
      m2_xs_q   <= m1_xs_q;
      m2_half_q <= m1_half_q;
    end
  end

  // Stages 3 and 4: fourth and fifth powers
  logic signed [CW-1:0] m3_r_q, m3_xs_q, m4_r_q;
  logic                 m3_half_q, m4_half_q;

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      m3_r_q    <= (cfg_i.curve_kind == CURVE_QUART || cfg_i.curve_kind == CURVE_QUINT)
                   ? fx_mul(m2_r_q, m2_xs_q) : m2_r_q;
      m3_xs_q   <= m2_xs_q;
      m3_half_q <= m2_half_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      m4_r_q    <= (cfg_i.curve_kind == CURVE_QUINT) ? fx_mul(m3_r_q, m3_xs_q) : m3_r_q;
      m4_half_q <= m3_half_q;
    end
  end

  // Stage 5: direction shaping, halving rounds half up
  logic signed [CW-1:0] h, f_d, f_q;

  always_comb begin
    h = (m4_r_q + CW'(1)) >>> 1;
    priority if (is_inout) begin
      f_d = m4_half_q ? h : ONE - h;
    end else if (is_out) begin
      f_d = ONE - m4_r_q;
    end else begin
      f_d = m4_r_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      f_q <= f_d;
    end
  end

  // Stage 6: change times curve
  logic signed [PW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      prod_q <= PW'(cfg_i.change_amount) * PW'(f_q);
    end
  end

  // Stage 7: round, offset, saturate
  logic signed [PW-1:0] rnd;
  logic signed [PW:0]   sum;
  logic                 sat_hi, sat_lo;
  logic signed [VALUE_BITS-1:0] value_q;
  logic                         sat_q;

  always_comb begin
    rnd    = (prod_q + PW'(HALF)) >>> F;
    sum    = (PW+1)'(rnd) + (PW+1)'(cfg_i.start_value);
    sat_hi = !sum[PW] && (sum[PW-1:VALUE_BITS-1] != '0);
    sat_lo = sum[PW] && (sum[PW-1:VALUE_BITS-1] != '1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      priority if (sat_hi) begin
        value_q <= {1'b0, {(VALUE_BITS-1){1'b1}}};
      end else if (sat_lo) begin
        value_q <= {1'b1, {(VALUE_BITS-1){1'b0}}};
      end else begin
        value_q <= sum[VALUE_BITS-1:0];
      end
      sat_q <= sat_hi | sat_lo;
    end
  end

  assign eased_value_o = value_q;
  assign saturated_o   = sat_q;

endmodule

`default_nettype wire
